[sv/salsa20_stream_cipher_core_assert.svh]
// assertion macros for the salsa20 stream cipher core
`ifndef SALSA20_STREAM_CIPHER_CORE_ASSERT_SVH
`define SALSA20_STREAM_CIPHER_CORE_ASSERT_SVH

// consequent checked in the same cycle as the antecedent
`define SSC_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent checked in the cycle after the antecedent
`define SSC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[sv/ssc_pkg.sv]
// shared types, constants and salsa20 round functions
`timescale 1ns / 1ps

package ssc_pkg;

	typedef logic [31:0]       word_t;
	typedef logic [15:0][31:0] blk_t;
	typedef logic [3:0][31:0]  quad_t;

	// configuration register indexes
	localparam logic [2:0] CFG_KEY0     = 3'd0;
	localparam logic [2:0] CFG_KEY1     = 3'd1;
	localparam logic [2:0] CFG_KEY2     = 3'd2;
	localparam logic [2:0] CFG_KEY3     = 3'd3;
	localparam logic [2:0] CFG_NONCE    = 3'd4;
	localparam logic [2:0] CFG_KEY_SIZE = 3'd5;

	// expansion constants
	localparam word_t SIGMA0     = 32'h61707865;
	localparam word_t SIGMA1_128 = 32'h3120646e;
	localparam word_t SIGMA1_256 = 32'h3320646e;
	localparam word_t SIGMA2_128 = 32'h79622d36;
	localparam word_t SIGMA2_256 = 32'h79622d32;
	localparam word_t SIGMA3     = 32'h6b206574;

	localparam int unsigned ROUNDS = 20;

	typedef struct packed {
		logic [63:0] key0;
		logic [63:0] key1;
		logic [63:0] key2;
		logic [63:0] key3;
		logic [63:0] nonce;
		logic        key_size;
	} cfg_t;

	typedef struct packed {
		logic        we;
		logic [4:0]  addr;
		word_t       data;
	} wr_t;

	typedef struct packed {
		logic done;
		logic bank;
	} gen_stat_t;

	typedef enum logic [1:0] {
		GEN_IDLE,
		GEN_ROUND,
		GEN_WRITE
	} gen_state_t;

	function automatic word_t rotl(input word_t v, input int unsigned n);
		return (v << n) | (v >> (32 - n));
	endfunction

	// quarter round, result ordered {a, b, c, d} from msb
	function automatic quad_t quarter(input word_t a, input word_t b,
	                                  input word_t c, input word_t d);
		word_t ta, tb, tc, td;
		tb = b ^ rotl(a + d, 7);
		tc = c ^ rotl(tb + a, 9);
		td = d ^ rotl(tc + tb, 13);
		ta = a ^ rotl(td + tc, 18);
		return {ta, tb, tc, td};
	endfunction

	// one round: column round when row is low, row round otherwise
	function automatic blk_t salsa_round(input blk_t x, input logic row);
		blk_t  y;
		quad_t q0, q1, q2, q3;
		if (!row) begin
			q0 = quarter(x[0],  x[4],  x[8],  x[12]);
			q1 = quarter(x[5],  x[9],  x[13], x[1]);
			q2 = quarter(x[10], x[14], x[2],  x[6]);
			q3 = quarter(x[15], x[3],  x[7],  x[11]);
			y[0]  = q0[3]; y[4]  = q0[2]; y[8]  = q0[1]; y[12] = q0[0];
			y[5]  = q1[3]; y[9]  = q1[2]; y[13] = q1[1]; y[1]  = q1[0];
			y[10] = q2[3]; y[14] = q2[2]; y[2]  = q2[1]; y[6]  = q2[0];
			y[15] = q3[3]; y[3]  = q3[2]; y[7]  = q3[1]; y[11] = q3[0];
		end else begin
			q0 = quarter(x[0],  x[1],  x[2],  x[3]);
			q1 = quarter(x[5],  x[6],  x[7],  x[4]);
			q2 = quarter(x[10], x[11], x[8],  x[9]);
			q3 = quarter(x[15], x[12], x[13], x[14]);
			y[0]  = q0[3]; y[1]  = q0[2]; y[2]  = q0[1]; y[3]  = q0[0];
			y[5]  = q1[3]; y[6]  = q1[2]; y[7]  = q1[1]; y[4]  = q1[0];
			y[10] = q2[3]; y[11] = q2[2]; y[8]  = q2[1]; y[9]  = q2[0];
			y[15] = q3[3]; y[12] = q3[2]; y[13] = q3[1]; y[14] = q3[0];
		end
		return y;
	endfunction

	// input block from key, nonce and block counter
	function automatic blk_t init_state(input cfg_t c, input logic [63:0] ctr);
		blk_t s;
		s[0]  = SIGMA0;
		s[5]  = c.key_size ? SIGMA1_256 : SIGMA1_128;
		s[10] = c.key_size ? SIGMA2_256 : SIGMA2_128;
		s[15] = SIGMA3;
		s[1]  = c.key0[31:0];
		s[2]  = c.key0[63:32];
		s[3]  = c.key1[31:0];
		s[4]  = c.key1[63:32];
		s[11] = c.key_size ? c.key2[31:0]  : c.key0[31:0];
		s[12] = c.key_size ? c.key2[63:32] : c.key0[63:32];
		s[13] = c.key_size ? c.key3[31:0]  : c.key1[31:0];
		s[14] = c.key_size ? c.key3[63:32] : c.key1[63:32];
		s[6]  = c.nonce[31:0];
		s[7]  = c.nonce[63:32];
		s[8]  = ctr[31:0];
		s[9]  = ctr[63:32];
		return s;
	endfunction

endpackage

[sv/ssc_ksbuf.sv]
// two-bank keystream buffer memory, 32 words, registered read
`timescale 1ns / 1ps

module ssc_ksbuf (
	input  logic          clk,
	input  ssc_pkg::wr_t  wr,
	input  logic          re,
	input  logic [4:0]    raddr,
	output ssc_pkg::word_t rdata
);
	import ssc_pkg::*;

	word_t mem [32];
	word_t rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (wr.we) begin
			mem[wr.addr] <= wr.data;
		end
	end

	// read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[sv/ssc_core.sv]
// salsa20 block generator: one round per cycle, one word written per cycle
`timescale 1ns / 1ps

module ssc_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              clear,
	input  ssc_pkg::cfg_t     cfg,
	input  logic              bank_free,
	output ssc_pkg::wr_t      wr,
	output ssc_pkg::gen_stat_t stat
);
	import ssc_pkg::*;

	gen_state_t  state_q, state_d;
	blk_t        x_q;
	blk_t        s;
	logic [4:0]  rc_q;
	logic [3:0]  widx_q;
	logic [63:0] ctr_q;
	logic        bank_q;
	logic        start, last_round, last_word;

	assign s          = init_state(cfg, ctr_q);
	assign start      = (state_q == GEN_IDLE) && bank_free;
	assign last_round = (rc_q == 5'(ROUNDS - 1));
	assign last_word  = (widx_q == 4'd15);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			GEN_IDLE:  if (bank_free) state_d = GEN_ROUND;
			GEN_ROUND: if (last_round) state_d = GEN_WRITE;
			GEN_WRITE: if (last_word) state_d = GEN_IDLE;
			default:   state_d = GEN_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		wr.we     = 1'b0;
		wr.addr   = {bank_q, widx_q};
		wr.data   = x_q[widx_q] + s[widx_q];
		stat.done = 1'b0;
		stat.bank = bank_q;
		case (state_q)
			GEN_WRITE: begin
				wr.we     = 1'b1;
				stat.done = last_word;
			end
			default: begin
				wr.we     = 1'b0;
				stat.done = 1'b0;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= GEN_IDLE;
			rc_q    <= '0;
			widx_q  <= '0;
			ctr_q   <= '0;
			bank_q  <= 1'b0;
		end else if (clear) begin
			state_q <= GEN_IDLE;
			rc_q    <= '0;
			widx_q  <= '0;
			ctr_q   <= '0;
			bank_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == GEN_ROUND) begin
				rc_q <= last_round ? 5'd0 : rc_q + 5'd1;
			end
			if (state_q == GEN_WRITE) begin
				widx_q <= widx_q + 4'd1;
				if (last_word) begin
					ctr_q  <= ctr_q + 64'd1;
					bank_q <= ~bank_q;
				end
			end
		end
	end

	// working block
	always_ff @(posedge clk) begin
		if (start) begin
			x_q <= s;
		end else if (state_q == GEN_ROUND) begin
			x_q <= salsa_round(x_q, rc_q[0]);
		end
	end

endmodule

[sv/salsa20_stream_cipher_core.sv]
// Salsa20/20 byte stream cipher, top level
// a transferred byte shows at the output in the cycle after it is taken
// throughput: one byte per cycle sustained while the output is not stalled; a 64-byte block
//   is made by a load, one round per cycle in the core, then one word per cycle into the buffer
// first byte after reset or a restarting config write waits until a block is in the buffer
// reset: asynchronous, clears config, counter, bank flags and pipeline
`timescale 1ns / 1ps

module salsa20_stream_cipher_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  plain_byte,
	input  logic        end_of_message,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  cipher_byte,
	output logic        last
);
	import ssc_pkg::*;

	cfg_t       cfg_q;
	logic       clear;
	logic [1:0] full_q;
	logic       rb_q;
	logic [5:0] pos_q;
	logic       valid_s1;
	logic [7:0] plain_s1;
	logic       last_s1;
	logic [1:0] sel_s1;
	logic       accept;
	word_t      rdata;
	wr_t        wr;
	gen_stat_t  stat;

	// config writes to listed registers restart the keystream
	assign clear = cfg_we && (cfg_index <= CFG_KEY_SIZE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_KEY0:     cfg_q.key0     <= cfg_data;
				CFG_KEY1:     cfg_q.key1     <= cfg_data;
				CFG_KEY2:     cfg_q.key2     <= cfg_data;
				CFG_KEY3:     cfg_q.key3     <= cfg_data;
				CFG_NONCE:    cfg_q.nonce    <= cfg_data;
				CFG_KEY_SIZE: cfg_q.key_size <= cfg_data[0];
				default:      cfg_q          <= cfg_q;
			endcase
		end
	end

	// block generator
	ssc_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.clear     (clear),
		.cfg       (cfg_q),
		.bank_free (!full_q[stat.bank]),
		.wr        (wr),
		.stat      (stat)
	);

	// keystream memory
	ssc_ksbuf u_ksbuf (
		.clk   (clk),
		.wr    (wr),
		.re    (accept),
		.raddr ({rb_q, pos_q[5:2]}),
		.rdata (rdata)
	);

	// input transfer when the read bank holds a block and the output can move
	assign in_stall = !(full_q[rb_q] && (!valid_s1 || !out_stall));
	assign accept   = in_valid && !in_stall;

	// bank flags and read position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_q <= '0;
			rb_q   <= 1'b0;
			pos_q  <= '0;
		end else if (clear) begin
			full_q <= '0;
			rb_q   <= 1'b0;
			pos_q  <= '0;
		end else begin
			if (stat.done) begin
				full_q[stat.bank] <= 1'b1;
			end
			if (accept) begin
				pos_q <= pos_q + 6'd1;
				if (pos_q == 6'd63) begin
					full_q[rb_q] <= 1'b0;
					rb_q         <= ~rb_q;
				end
			end
		end
	end

	// output stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (!out_stall) begin
			valid_s1 <= 1'b0;
		end
	end

	// output stage payload
	always_ff @(posedge clk) begin
		if (accept) begin
			plain_s1 <= plain_byte;
			last_s1  <= end_of_message;
			sel_s1   <= pos_q[1:0];
		end
	end

	assign out_valid   = valid_s1;
	assign cipher_byte = plain_s1 ^ rdata[{sel_s1, 3'b000} +: 8];
	assign last        = last_s1;

endmodule

[sv/ssc_checker.sv]
// port-level checker for the salsa20 stream cipher core, with bind
`timescale 1ns / 1ps

`include "salsa20_stream_cipher_core_assert.svh"

module ssc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        cfg_we,
	input logic [2:0]  cfg_index,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [7:0]  cipher_byte,
	input logic        last
);
	import ssc_pkg::*;

	// stalled output holds
	`SSC_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "output dropped while stalled")
	`SSC_ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(cipher_byte) && $stable(last), "stalled payload changed")
	// a restart empties the buffer, so no transfer can follow at once
	`SSC_ASSERT_NEXT(a_cfg_empty, cfg_we && (cfg_index <= CFG_KEY_SIZE), in_stall, "input taken right after restart")
	// every input transfer yields an output next cycle
	`SSC_ASSERT_NEXT(a_in_out, in_valid && !in_stall, out_valid, "input transfer without output")

endmodule

bind salsa20_stream_cipher_core ssc_checker u_ssc_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.cfg_we      (cfg_we),
	.cfg_index   (cfg_index),
	.in_valid    (in_valid),
	.in_stall    (in_stall),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.cipher_byte (cipher_byte),
	.last        (last)
);
